>>> src/sgov_pkg.sv
// sgov_pkg: shared widths and request/response types for the governor step
// used by sgov_mul and steam_governor_step; depends on nothing
`timescale 1ns / 1ps

package sgov_pkg;

  localparam int SIG_W  = 48;
  localparam int GAIN_W = 47;

  localparam logic signed [SIG_W-1:0] SIG_MAX = {1'b0, {(SIG_W-1){1'b1}}};
  localparam logic signed [SIG_W-1:0] SIG_MIN = {1'b1, {(SIG_W-1){1'b0}}};

  // multiply request from the sequencer
  typedef struct packed {
    logic                    start;
    logic signed [SIG_W-1:0] a;
    logic signed [SIG_W-1:0] b;
  } sgov_mul_req_t;

  // multiply response: done pulses for one cycle with the rounded result
  typedef struct packed {
    logic                    done;
    logic signed [SIG_W-1:0] result;
  } sgov_mul_rsp_t;

endpackage

>>> src/steam_governor_step.sv
// steam_governor_step: top level of the steam turbine governor step
// sequencer, saturating adder, apb registers; depends on sgov_pkg, sgov_mul
//   a restart goes straight to the done state; lag mode runs more multiplies
//   than derivative mode; one item at a time, so a new transfer is taken only
//   in idle, and the done state waits for a free output register
//   every multiply runs on the one shared multiplier (four 24x24 partial
//   products, round, handoff), which sets the item time
//   reset: synchronous, apb registers take their reset values, governor state clears
`timescale 1ns / 1ps

module steam_governor_step
  import sgov_pkg::*;
#(
  parameter int FRAC_BITS = 32
) (
  input  logic                    clk,
  input  logic                    rst,
  // input channel
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [SIG_W-1:0] speed,
  input  logic                    restart,
  // output channel
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [SIG_W-1:0] gate_position,
  output logic                    gate_clamped,
  // configuration port
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [5:0]              paddr,
  input  logic [63:0]             pwdata,
  output logic [63:0]             prdata,
  output logic                    pready
);

  // packed halves are Q8.24; align them to the signal fraction
  localparam int SH_L = (FRAC_BITS >= 24) ? FRAC_BITS - 24 : 0;
  localparam int SH_R = (FRAC_BITS < 24) ? 24 - FRAC_BITS : 0;
  localparam logic signed [SIG_W-1:0] ONE_F = SIG_W'(1) << FRAC_BITS;

  // register map, 8 bytes apart
  localparam logic [2:0] REG_REFS      = 3'd0;
  localparam logic [2:0] REG_DROOP     = 3'd1;
  localparam logic [2:0] REG_LAG_STEP  = 3'd2;
  localparam logic [2:0] REG_LEAD      = 3'd3;
  localparam logic [2:0] REG_GATE_GAIN = 3'd4;
  localparam logic [2:0] REG_RATE_LIM  = 3'd5;
  localparam logic [2:0] REG_GATE_LIM  = 3'd6;
  localparam logic [2:0] REG_BACKCALC  = 3'd7;

  localparam logic [63:0]       RST_REFS     = 64'd16777216;
  localparam logic [GAIN_W-1:0] RST_DROOP    = GAIN_W'(85899345);
  localparam logic [63:0]       RST_GATE_LIM = 64'd72057594037927936;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_L_MUL_LEAD,   // t = e1 * lead
    ST_L_ADD_P,      // t = lag + t
    ST_D_SUB,        // t = e1 - e2
    ST_D_MUL,        // t = lead * t
    ST_D_ADD,        // t = e1 + t
    ST_MUL_DROOP,    // p = droop * t
    ST_L_CB,         // t = 1 - lead
    ST_L_MUL_CB,     // t = e1 * t
    ST_L_SUB,        // t = t - lag
    ST_L_MUL_STEP,   // t = lag_step * t
    ST_L_ACC,        // lag = lag + t
    ST_G_PREF,       // t = pref + p
    ST_G_ERR,        // t = t - held
    ST_G_MUL_GAIN,   // d = gain * t
    ST_G_RATE,       // rate clamp on d
    ST_G_DIFF,       // t = unl - held
    ST_G_MUL_BC,     // t = bc * t
    ST_G_SUB,        // d = d - t
    ST_G_INT,        // unl = unl + d
    ST_G_LIMIT,      // output clamp
    ST_G_SPEED,      // shift the error line
    ST_DONE          // hand result to the output register
  } state_t;

  // configuration registers
  logic [63:0]       refs_packed;
  logic [GAIN_W-1:0] droop_gain;
  logic [32:0]       lag_step;
  logic [GAIN_W-1:0] lead_coef;
  logic [GAIN_W-1:0] gate_step_gain;
  logic [63:0]       rate_limits;
  logic [63:0]       gate_limits;
  logic [GAIN_W-1:0] backcalc_gain;

  // governor state
  logic signed [SIG_W-1:0] last_error;
  logic signed [SIG_W-1:0] older_error;
  logic signed [SIG_W-1:0] lag_value;
  logic signed [SIG_W-1:0] gate_unlimited;
  logic signed [SIG_W-1:0] gate_held;

  // working registers
  state_t                  state;
  logic signed [SIG_W-1:0] speed_q;
  logic signed [SIG_W-1:0] t;
  logic signed [SIG_W-1:0] p;
  logic signed [SIG_W-1:0] d;
  logic                    clamp_flag;

  logic signed [SIG_W-1:0] spd_ref, pref, rmin, rmax, pmin, pmax;
  logic signed [SIG_W-1:0] alu_a, alu_b, alu_y;
  logic                    alu_sub;
  logic signed [SIG_W-1:0] d_lo;
  logic                    cfg_wr;
  logic [2:0]              cfg_idx;

  sgov_mul_req_t mreq;
  sgov_mul_rsp_t mrsp;

  function automatic logic signed [SIG_W-1:0] half_to_sig(input logic [31:0] h);
    logic signed [SIG_W-1:0] hx;
    hx = $signed({{(SIG_W-32){h[31]}}, h});
    return (hx <<< SH_L) >>> SH_R;
  endfunction

  function automatic logic signed [SIG_W-1:0] sat_add(
    input logic signed [SIG_W-1:0] a,
    input logic signed [SIG_W-1:0] b,
    input logic                    sub
  );
    logic [SIG_W:0] s;
    s = sub ? ({a[SIG_W-1], a} - {b[SIG_W-1], b})
            : ({a[SIG_W-1], a} + {b[SIG_W-1], b});
    if (s[SIG_W] != s[SIG_W-1]) begin
      return s[SIG_W] ? SIG_MIN : SIG_MAX;
    end
    return $signed(s[SIG_W-1:0]);
  endfunction

  // ---------------------------------------------------------------------
  // apb registers: write on the access cycle, pready tied high
  // ---------------------------------------------------------------------
  assign pready  = 1'b1;
  assign cfg_idx = paddr[5:3];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      refs_packed    <= RST_REFS;
      droop_gain     <= RST_DROOP;
      lag_step       <= '0;
      lead_coef      <= '0;
      gate_step_gain <= '0;
      rate_limits    <= '0;
      gate_limits    <= RST_GATE_LIM;
      backcalc_gain  <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_REFS:      refs_packed    <= pwdata;
        REG_DROOP:     droop_gain     <= pwdata[GAIN_W-1:0];
        REG_LAG_STEP:  lag_step       <= pwdata[32:0];
        REG_LEAD:      lead_coef      <= pwdata[GAIN_W-1:0];
        REG_GATE_GAIN: gate_step_gain <= pwdata[GAIN_W-1:0];
        REG_RATE_LIM:  rate_limits    <= pwdata;
        REG_GATE_LIM:  gate_limits    <= pwdata;
        REG_BACKCALC:  backcalc_gain  <= pwdata[GAIN_W-1:0];
        default:       ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_REFS:      prdata = refs_packed;
      REG_DROOP:     prdata = 64'(droop_gain);
      REG_LAG_STEP:  prdata = 64'(lag_step);
      REG_LEAD:      prdata = 64'(lead_coef);
      REG_GATE_GAIN: prdata = 64'(gate_step_gain);
      REG_RATE_LIM:  prdata = rate_limits;
      REG_GATE_LIM:  prdata = gate_limits;
      REG_BACKCALC:  prdata = 64'(backcalc_gain);
      default:       prdata = '0;
    endcase
  end

  // references and limits in signal format
  assign spd_ref = half_to_sig(refs_packed[31:0]);
  assign pref    = half_to_sig(refs_packed[63:32]);
  assign rmin    = half_to_sig(rate_limits[31:0]);
  assign rmax    = half_to_sig(rate_limits[63:32]);
  assign pmin    = half_to_sig(gate_limits[31:0]);
  assign pmax    = half_to_sig(gate_limits[63:32]);

  // ---------------------------------------------------------------------
  // shared saturating adder: operands picked by the sequencer state
  // ---------------------------------------------------------------------
  always_comb begin
    alu_a   = t;
    alu_b   = lag_value;
    alu_sub = 1'b0;
    unique case (state)
      ST_L_ADD_P: begin alu_a = lag_value;      alu_b = t; end
      ST_L_CB: begin
        alu_a   = ONE_F;
        alu_b   = $signed({1'b0, lead_coef});
        alu_sub = 1'b1;
      end
      ST_L_SUB:   begin alu_a = t;              alu_b = lag_value;   alu_sub = 1'b1; end
      ST_L_ACC:   begin alu_a = lag_value;      alu_b = t; end
      ST_D_SUB:   begin alu_a = last_error;     alu_b = older_error; alu_sub = 1'b1; end
      ST_D_ADD:   begin alu_a = last_error;     alu_b = t; end
      ST_G_PREF:  begin alu_a = pref;           alu_b = p; end
      ST_G_ERR:   begin alu_a = t;              alu_b = gate_held;   alu_sub = 1'b1; end
      ST_G_DIFF:  begin alu_a = gate_unlimited; alu_b = gate_held;   alu_sub = 1'b1; end
      ST_G_SUB:   begin alu_a = d;              alu_b = t;           alu_sub = 1'b1; end
      ST_G_INT:   begin alu_a = gate_unlimited; alu_b = d; end
      ST_G_SPEED: begin alu_a = spd_ref;        alu_b = speed_q;     alu_sub = 1'b1; end
      default:    ;
    endcase
    alu_y = sat_add(alu_a, alu_b, alu_sub);
  end

  // ---------------------------------------------------------------------
  // shared multiplier: operands picked by the sequencer state
  // ---------------------------------------------------------------------
  always_comb begin
    mreq.start = 1'b1;
    mreq.a     = t;
    mreq.b     = t;
    unique case (state)
      ST_L_MUL_LEAD: begin mreq.a = last_error; mreq.b = $signed({1'b0, lead_coef}); end
      ST_D_MUL:      begin mreq.a = $signed({1'b0, lead_coef});      mreq.b = t; end
      ST_MUL_DROOP:  begin mreq.a = $signed({1'b0, droop_gain});     mreq.b = t; end
      ST_L_MUL_CB:   begin mreq.a = last_error;                      mreq.b = t; end
      ST_L_MUL_STEP: begin mreq.a = $signed(SIG_W'(lag_step));       mreq.b = t; end
      ST_G_MUL_GAIN: begin mreq.a = $signed({1'b0, gate_step_gain}); mreq.b = t; end
      ST_G_MUL_BC:   begin mreq.a = $signed({1'b0, backcalc_gain});  mreq.b = t; end
      default:       mreq.start = 1'b0;
    endcase
  end

  sgov_mul #(
    .FRAC_BITS(FRAC_BITS)
  ) u_mul (
    .clk(clk),
    .rst(rst),
    .req(mreq),
    .rsp(mrsp)
  );

  // lower rate limit first, upper limit applied last wins
  assign d_lo = (d < rmin) ? rmin : d;

  assign in_stall = (state != ST_IDLE);

  // ---------------------------------------------------------------------
  // sequencer, state and registered outputs
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      out_valid      <= 1'b0;
      last_error     <= '0;
      older_error    <= '0;
      lag_value      <= '0;
      // power reference from the reset register value is zero
      gate_unlimited <= '0;
      gate_held      <= '0;
      clamp_flag     <= 1'b0;
    end else begin
      // the done state reloads the output register itself
      if (out_valid && !out_stall && state != ST_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            speed_q <= speed;
            if (restart) begin
              // restart: clear state, gate goes straight to the power reference
              last_error     <= '0;
              older_error    <= '0;
              lag_value      <= '0;
              gate_unlimited <= pref;
              gate_held      <= pref;
              clamp_flag     <= 1'b0;
              state          <= ST_DONE;
            end else if (lag_step == '0) begin
              state <= ST_D_SUB;
            end else begin
              state <= ST_L_MUL_LEAD;
            end
          end
        end
        // lead-lag form
        ST_L_MUL_LEAD: if (mrsp.done) begin t <= mrsp.result; state <= ST_L_ADD_P; end
        ST_L_ADD_P: begin
          t     <= alu_y;
          state <= ST_MUL_DROOP;
        end
        // lead-derivative form
        ST_D_SUB: begin
          t     <= alu_y;
          state <= ST_D_MUL;
        end
        ST_D_MUL: if (mrsp.done) begin t <= mrsp.result; state <= ST_D_ADD; end
        ST_D_ADD: begin
          t     <= alu_y;
          state <= ST_MUL_DROOP;
        end
        ST_MUL_DROOP: begin
          if (mrsp.done) begin
            p     <= mrsp.result;
            state <= (lag_step == '0) ? ST_G_PREF : ST_L_CB;
          end
        end
        // lag state update, may use a negative cb
        ST_L_CB: begin
          t     <= alu_y;
          state <= ST_L_MUL_CB;
        end
        ST_L_MUL_CB: if (mrsp.done) begin t <= mrsp.result; state <= ST_L_SUB; end
        ST_L_SUB: begin
          t     <= alu_y;
          state <= ST_L_MUL_STEP;
        end
        ST_L_MUL_STEP: if (mrsp.done) begin t <= mrsp.result; state <= ST_L_ACC; end
        ST_L_ACC: begin
          lag_value <= alu_y;
          state     <= ST_G_PREF;
        end
        // rate-limited integrator with back-calculation
        ST_G_PREF: begin
          t     <= alu_y;
          state <= ST_G_ERR;
        end
        ST_G_ERR: begin
          t     <= alu_y;
          state <= ST_G_MUL_GAIN;
        end
        ST_G_MUL_GAIN: if (mrsp.done) begin d <= mrsp.result; state <= ST_G_RATE; end
        ST_G_RATE: begin
          d     <= (d_lo > rmax) ? rmax : d_lo;
          state <= ST_G_DIFF;
        end
        ST_G_DIFF: begin
          t     <= alu_y;
          state <= ST_G_MUL_BC;
        end
        ST_G_MUL_BC: if (mrsp.done) begin t <= mrsp.result; state <= ST_G_SUB; end
        ST_G_SUB: begin
          d     <= alu_y;
          state <= ST_G_INT;
        end
        ST_G_INT: begin
          gate_unlimited <= alu_y;
          state          <= ST_G_LIMIT;
        end
        // output clamp, lower limit tested first
        ST_G_LIMIT: begin
          if (gate_unlimited < pmin) begin
            gate_held  <= pmin;
            clamp_flag <= 1'b1;
          end else if (gate_unlimited > pmax) begin
            gate_held  <= pmax;
            clamp_flag <= 1'b1;
          end else begin
            gate_held  <= gate_unlimited;
            clamp_flag <= 1'b0;
          end
          state <= ST_G_SPEED;
        end
        // speed error is stored here and enters at the next item
        ST_G_SPEED: begin
          older_error <= last_error;
          last_error  <= alu_y;
          state       <= ST_DONE;
        end
        ST_DONE: begin
          // wait for a free output register
          if (!out_valid || !out_stall) begin
            gate_position <= gate_held;
            gate_clamped  <= clamp_flag;
            out_valid     <= 1'b1;
            state         <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------
  a_restart_clears: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && restart) |=>
      (state == ST_DONE && lag_value == '0 && last_error == '0 &&
       older_error == '0 && gate_unlimited == gate_held && !clamp_flag))
    else $error("restart did not clear the governor state");

  a_mul_done_owned: assert property (@(posedge clk) disable iff (rst)
    mrsp.done |-> mreq.start)
    else $error("multiplier finished with no request outstanding");

  a_clamp_flag: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE) |-> (clamp_flag == (gate_held != gate_unlimited)))
    else $error("clamp flag disagrees with the held gate");

endmodule

>>> src/sgov_mul.sv
// sgov_mul: shared signed fixed-point multiplier, four 24x24 partial products
// then round half away from zero and saturate; depends on sgov_pkg
`timescale 1ns / 1ps

module sgov_mul
  import sgov_pkg::*;
#(
  parameter int FRAC_BITS = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  sgov_mul_req_t req,
  output sgov_mul_rsp_t rsp
);

  localparam int HALF_W = SIG_W / 2;
  localparam int PROD_W = 2 * SIG_W;

  typedef enum logic [1:0] {MU_IDLE, MU_PP, MU_RND} mu_state_t;

  mu_state_t            mstate;
  logic [1:0]           cnt;
  logic [SIG_W-1:0]     ma;
  logic [SIG_W-1:0]     mb;
  logic                 neg;
  logic [PROD_W-1:0]    acc;

  logic [HALF_W-1:0]    a_half;
  logic [HALF_W-1:0]    b_half;
  logic [SIG_W-1:0]     pp;
  logic [PROD_W-1:0]    pp_sh;
  logic [PROD_W:0]      rnd;
  logic [PROD_W:0]      mag;
  logic                 ovf;
  logic signed [SIG_W-1:0] res_val;

  // one partial product per cycle
  always_comb begin
    a_half = cnt[1] ? ma[SIG_W-1:HALF_W] : ma[HALF_W-1:0];
    b_half = cnt[0] ? mb[SIG_W-1:HALF_W] : mb[HALF_W-1:0];
    pp     = SIG_W'(a_half) * SIG_W'(b_half);
    case ({1'b0, cnt[1]} + {1'b0, cnt[0]})
      2'd0:    pp_sh = PROD_W'(pp);
      2'd1:    pp_sh = PROD_W'(pp) << HALF_W;
      default: pp_sh = PROD_W'(pp) << SIG_W;
    endcase
  end

  // round, drop fraction, saturate
  always_comb begin
    rnd = {1'b0, acc} + ((PROD_W+1)'(1) << (FRAC_BITS - 1));
    mag = rnd >> FRAC_BITS;
    ovf = |mag[PROD_W:SIG_W-1];
    if (ovf) begin
      res_val = neg ? SIG_MIN : SIG_MAX;
    end else if (neg) begin
      res_val = -$signed({1'b0, mag[SIG_W-2:0]});
    end else begin
      res_val = $signed({1'b0, mag[SIG_W-2:0]});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mstate   <= MU_IDLE;
      cnt      <= '0;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= 1'b0;
      unique case (mstate)
        MU_IDLE: begin
          if (req.start && !rsp.done) begin
            ma     <= req.a[SIG_W-1] ? SIG_W'(-req.a) : req.a;
            mb     <= req.b[SIG_W-1] ? SIG_W'(-req.b) : req.b;
            neg    <= req.a[SIG_W-1] ^ req.b[SIG_W-1];
            acc    <= '0;
            cnt    <= '0;
            mstate <= MU_PP;
          end
        end
        MU_PP: begin
          acc <= acc + pp_sh;
          cnt <= cnt + 2'd1;
          if (cnt == 2'd3) begin
            mstate <= MU_RND;
          end
        end
        MU_RND: begin
          rsp.result <= res_val;
          rsp.done   <= 1'b1;
          mstate     <= MU_IDLE;
        end
        default: mstate <= MU_IDLE;
      endcase
    end
  end

endmodule
